[hw/rtl/pfc_pkg.sv]
// ----------------------------------------------------------------------------
// pfc_pkg
// Types, constants and small helpers for the limited face flux pipeline.
// ----------------------------------------------------------------------------
package pfc_pkg;

  // one stencil transfer
  typedef struct packed {
    logic signed [31:0] f_far_left;
    logic signed [31:0] f_left;
    logic signed [31:0] f_center;
    logic signed [31:0] f_right;
    logic signed [31:0] f_far_right;
    logic signed [31:0] courant;
  } pfc_in_t;

  // one flux transfer
  typedef struct packed {
    logic signed [31:0] flux;
    logic               saturated;
  } pfc_out_t;

  // courant limits in Q2.30
  localparam logic signed [31:0] NU_POS_ONE = 32'sh4000_0000;
  localparam logic signed [31:0] NU_NEG_ONE = 32'shC000_0000;

  // 1.0 and 2.0 in Q.30 on 33 bits
  localparam logic signed [32:0] Q30_ONE = 33'sh0_4000_0000;
  localparam logic signed [32:0] Q30_TWO = 33'sh0_8000_0000;

  // floor(x / 3) = (x * RECIP3) >> RECIP3_SHIFT, exact for x < 2^33
  localparam logic [32:0] RECIP3       = 33'd5726623062;
  localparam int          RECIP3_SHIFT = 34;

  // output range
  localparam logic signed [41:0] FLUX_MAX = 42'sd2147483647;
  localparam logic signed [41:0] FLUX_MIN = -42'sd2147483648;

  function automatic logic signed [33:0] max34(input logic signed [33:0] a,
                                               input logic signed [33:0] b);
    return (a > b) ? a : b;
  endfunction

  function automatic logic signed [33:0] min34(input logic signed [33:0] a,
                                               input logic signed [33:0] b);
    return (a < b) ? a : b;
  endfunction

  // v / 2^30, rounded to nearest with ties away from zero
  function automatic logic signed [71:0] rnd30(input logic signed [71:0] v);
    logic signed [71:0] half;
    half = v[71] ? 72'sd536870911 : 72'sd536870912;
    return (v + half) >>> 30;
  endfunction

endpackage

[hw/rtl/pfc_limited_flux.sv]
// ----------------------------------------------------------------------------
// pfc_limited_flux
// Limited third-order upwind-biased face flux from a five-point stencil and a
// signed Courant number, as a fourteen-stage pipeline with saturated output.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake              payload
//  in_      input      in_valid / in_stall    pfc_in_t  (stencil, courant)
//  out_     output     out_valid / out_stall  pfc_out_t (flux, saturated)
//
//  One transfer per cycle while out_stall is low; each transfer passes through
//  one register stage after another (bounds, coefficient products, divide by
//  six, slope products, rounding, sum, saturation).
//  Every stage holds its own valid bit; a stage loads when it is empty or
//  the stage after it moves, so bubbles close up while out_stall is high.
//  rst_n clears only the valid bits; payload registers are not reset.
//
module pfc_limited_flux
  import pfc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  pfc_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output pfc_out_t out_data
);

  localparam int NSTG = 14;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] en;

  // stage 0: clamp, extrapolations, one-sided differences
  logic signed [31:0] s0_nu_nxt;
  logic               s0_neg_nxt;
  logic signed [33:0] s0_e1_nxt, s0_e2_nxt, s0_e3_nxt, s0_e4_nxt;
  logic signed [32:0] s0_d_nxt, s0_g_nxt;
  logic signed [31:0] s0_nu_r, s0_fm1_r, s0_f0_r, s0_fp1_r;
  logic               s0_neg_r;
  logic signed [33:0] s0_e1_r, s0_e2_r, s0_e3_r, s0_e4_r;
  logic signed [32:0] s0_d_r, s0_g_r;

  // stage 1: partial bounds, polynomial factors
  logic signed [33:0] s1_hi1_nxt, s1_hi2_nxt, s1_lo1_nxt, s1_lo2_nxt;
  logic signed [32:0] s1_b1_nxt, s1_c1_nxt, s1_b2_nxt, s1_c2_nxt;
  logic signed [33:0] s1_hi1_r, s1_hi2_r, s1_lo1_r, s1_lo2_r;
  logic signed [32:0] s1_b1_r, s1_c1_r, s1_b2_r, s1_c2_r;
  logic signed [31:0] s1_nu_r, s1_fsel_r, s1_f0_r;
  logic signed [32:0] s1_d_r, s1_g_r;

  // stage 2: bounds, first products
  logic signed [64:0] s2_mb1, s2_mb2;
  logic signed [63:0] s2_mf;
  logic signed [33:0] s2_fmax_r, s2_fmin_r;
  logic signed [63:0] s2_pr1_r, s2_pr2_r, s2_prf_r;
  logic signed [32:0] s2_c1_r, s2_c2_r;
  logic signed [31:0] s2_f0_r;
  logic signed [32:0] s2_d_r, s2_g_r;

  // stage 3: rounded first products, slope candidates
  logic signed [71:0] s3_rp1, s3_rp2, s3_rtnu;
  logic signed [35:0] s3_lplo_nxt, s3_lphi_nxt, s3_lmhi_nxt, s3_lmlo_nxt;
  logic signed [33:0] s3_p1_r, s3_p2_r;
  logic signed [32:0] s3_tnu_r;
  logic signed [32:0] s3_c1_r, s3_c2_r;
  logic signed [35:0] s3_lplo_r, s3_lphi_r, s3_lmhi_r, s3_lmlo_r;
  logic signed [32:0] s3_d_r, s3_g_r;

  // stage 4: limited slopes, second products
  logic signed [35:0] s4_dx, s4_gx;
  logic signed [35:0] s4_lp_nxt, s4_lm_nxt;
  logic signed [66:0] s4_mq1, s4_mq2;
  logic signed [63:0] s4_qr1_r, s4_qr2_r;
  logic signed [35:0] s4_lp_r, s4_lm_r;
  logic signed [32:0] s4_tnu_r;

  // stage 5: rounded second products
  logic signed [71:0] s5_rq1, s5_rq2;
  logic signed [33:0] s5_q1_r, s5_q2_r;
  logic signed [35:0] s5_lp_r, s5_lm_r;
  logic signed [32:0] s5_tnu_r;

  // stage 6: magnitude plus three, halved
  logic [33:0] s6_aq1, s6_aq2;
  logic [34:0] s6_aq1p, s6_aq2p;
  logic [32:0] s6_x1_r, s6_x2_r;
  logic        s6_sg1_r, s6_sg2_r;
  logic signed [35:0] s6_lp_r, s6_lm_r;
  logic signed [32:0] s6_tnu_r;

  // stage 7: reciprocal product for the divide by three
  logic [65:0] s7_m1_r, s7_m2_r;
  logic        s7_sg1_r, s7_sg2_r;
  logic signed [35:0] s7_lp_r, s7_lm_r;
  logic signed [32:0] s7_tnu_r;

  // stage 8: signed coefficients
  logic [31:0] s8_km1, s8_km2;
  logic signed [32:0] s8_k1_nxt, s8_k2_nxt;
  logic signed [32:0] s8_k1_r, s8_k2_r;
  logic signed [35:0] s8_lp_r, s8_lm_r;
  logic signed [32:0] s8_tnu_r;

  // stage 9: partial products of coefficient and slope
  logic signed [50:0] s9_pph1, s9_pph2;
  logic signed [51:0] s9_ppl1, s9_ppl2;
  logic signed [50:0] s9_pph1_r, s9_pph2_r;
  logic signed [51:0] s9_ppl1_r, s9_ppl2_r;
  logic signed [32:0] s9_tnu_r;

  // stage 10: full products
  logic signed [68:0] s10_kl1_nxt, s10_kl2_nxt;
  logic signed [68:0] s10_kl1_r, s10_kl2_r;
  logic signed [32:0] s10_tnu_r;

  // stage 11: rounded terms
  logic signed [71:0] s11_rt1, s11_rt2;
  logic signed [38:0] s11_t1_r, s11_t2_r;
  logic signed [32:0] s11_tnu_r;

  // stage 12: sum
  logic signed [41:0] s12_sum_nxt;
  logic signed [41:0] s12_sum_r;

  // stage 13: saturated result
  logic signed [31:0] s13_flux_nxt;
  logic               s13_sat_nxt;
  logic signed [31:0] s13_flux_r;
  logic               s13_sat_r;

  // --------------------------------------------------------------------------
  // flow control
  // --------------------------------------------------------------------------
  always_comb begin
    en[NSTG-1] = !v_r[NSTG-1] || !out_stall;
    for (int i = NSTG - 2; i >= 0; i--) begin
      en[i] = !v_r[i] || en[i+1];
    end
  end

  assign in_stall  = !en[0];
  assign out_valid = v_r[NSTG-1];
  assign out_data  = '{flux: s13_flux_r, saturated: s13_sat_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_valid;
      end
      for (int i = 1; i < NSTG; i++) begin
        if (en[i]) begin
          v_r[i] <= v_r[i-1];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // datapath
  // --------------------------------------------------------------------------
  always_comb begin
    if (in_data.courant > NU_POS_ONE) begin
      s0_nu_nxt = NU_POS_ONE;
    end else if (in_data.courant < NU_NEG_ONE) begin
      s0_nu_nxt = NU_NEG_ONE;
    end else begin
      s0_nu_nxt = in_data.courant;
    end
  end

  assign s0_neg_nxt = in_data.courant[31];
  assign s0_e1_nxt  = (34'(in_data.f_left) <<< 1) - 34'(in_data.f_far_left);
  assign s0_e2_nxt  = (34'(in_data.f_center) <<< 1) - 34'(in_data.f_right);
  assign s0_e3_nxt  = (34'(in_data.f_right) <<< 1) - 34'(in_data.f_far_right);
  assign s0_e4_nxt  = (34'(in_data.f_center) <<< 1) - 34'(in_data.f_left);
  // slope differences, oriented by the flow direction
  assign s0_d_nxt = s0_neg_nxt ? 33'(in_data.f_center) - 33'(in_data.f_right)
                               : 33'(in_data.f_right) - 33'(in_data.f_center);
  assign s0_g_nxt = s0_neg_nxt ? 33'(in_data.f_right) - 33'(in_data.f_far_right)
                               : 33'(in_data.f_center) - 33'(in_data.f_left);

  assign s1_hi1_nxt = max34(max34(34'(s0_fm1_r), 34'(s0_f0_r)), min34(s0_e1_r, s0_e2_r));
  assign s1_hi2_nxt = max34(max34(34'(s0_fp1_r), 34'(s0_f0_r)), min34(s0_e3_r, s0_e4_r));
  assign s1_lo1_nxt = min34(min34(34'(s0_fm1_r), 34'(s0_f0_r)), max34(s0_e1_r, s0_e2_r));
  assign s1_lo2_nxt = min34(min34(34'(s0_fp1_r), 34'(s0_f0_r)), max34(s0_e3_r, s0_e4_r));
  assign s1_b1_nxt  = s0_neg_r ? Q30_ONE + 33'(s0_nu_r) : Q30_ONE - 33'(s0_nu_r);
  assign s1_c1_nxt  = s0_neg_r ? Q30_TWO + 33'(s0_nu_r) : Q30_TWO - 33'(s0_nu_r);
  assign s1_b2_nxt  = Q30_ONE - 33'(s0_nu_r);
  assign s1_c2_nxt  = Q30_ONE + 33'(s0_nu_r);

  assign s2_mb1 = s1_nu_r * s1_b1_r;
  assign s2_mb2 = s1_nu_r * s1_b2_r;
  assign s2_mf  = s1_nu_r * s1_fsel_r;

  assign s3_rp1      = rnd30(72'(s2_pr1_r));
  assign s3_rp2      = rnd30(72'(s2_pr2_r));
  assign s3_rtnu     = rnd30(72'(s2_prf_r));
  assign s3_lplo_nxt = (36'(s2_f0_r) - 36'(s2_fmin_r)) <<< 1;
  assign s3_lphi_nxt = (36'(s2_f0_r) - 36'(s2_fmax_r)) <<< 1;
  assign s3_lmhi_nxt = (36'(s2_fmax_r) - 36'(s2_f0_r)) <<< 1;
  assign s3_lmlo_nxt = (36'(s2_fmin_r) - 36'(s2_f0_r)) <<< 1;

  assign s4_dx = 36'(s3_d_r);
  assign s4_gx = 36'(s3_g_r);
  assign s4_lp_nxt = !s3_d_r[32] ? ((s3_lplo_r < s4_dx) ? s3_lplo_r : s4_dx)
                                 : ((s3_lphi_r > s4_dx) ? s3_lphi_r : s4_dx);
  assign s4_lm_nxt = !s3_g_r[32] ? ((s3_lmhi_r < s4_gx) ? s3_lmhi_r : s4_gx)
                                 : ((s3_lmlo_r > s4_gx) ? s3_lmlo_r : s4_gx);
  assign s4_mq1 = s3_p1_r * s3_c1_r;
  assign s4_mq2 = s3_p2_r * s3_c2_r;

  assign s5_rq1 = rnd30(72'(s4_qr1_r));
  assign s5_rq2 = rnd30(72'(s4_qr2_r));

  // divide by six as ((|q| + 3) >> 1) / 3
  assign s6_aq1  = s5_q1_r[33] ? 34'(-s5_q1_r) : 34'(s5_q1_r);
  assign s6_aq2  = s5_q2_r[33] ? 34'(-s5_q2_r) : 34'(s5_q2_r);
  assign s6_aq1p = 35'(s6_aq1) + 35'd3;
  assign s6_aq2p = 35'(s6_aq2) + 35'd3;

  assign s8_km1    = s7_m1_r[RECIP3_SHIFT +: 32];
  assign s8_km2    = s7_m2_r[RECIP3_SHIFT +: 32];
  assign s8_k1_nxt = s7_sg1_r ? -$signed({1'b0, s8_km1}) : $signed({1'b0, s8_km1});
  assign s8_k2_nxt = s7_sg2_r ? -$signed({1'b0, s8_km2}) : $signed({1'b0, s8_km2});

  // slope split into a signed upper half and an unsigned lower half
  assign s9_pph1 = s8_k1_r * $signed(s8_lp_r[35:18]);
  assign s9_pph2 = s8_k2_r * $signed(s8_lm_r[35:18]);
  assign s9_ppl1 = s8_k1_r * $signed({1'b0, s8_lp_r[17:0]});
  assign s9_ppl2 = s8_k2_r * $signed({1'b0, s8_lm_r[17:0]});

  assign s10_kl1_nxt = (69'(s9_pph1_r) <<< 18) + 69'(s9_ppl1_r);
  assign s10_kl2_nxt = (69'(s9_pph2_r) <<< 18) + 69'(s9_ppl2_r);

  assign s11_rt1 = rnd30(72'(s10_kl1_r));
  assign s11_rt2 = rnd30(72'(s10_kl2_r));

  assign s12_sum_nxt = 42'(s11_tnu_r) + 42'(s11_t1_r) + 42'(s11_t2_r);

  always_comb begin
    if (s12_sum_r > FLUX_MAX) begin
      s13_flux_nxt = FLUX_MAX[31:0];
      s13_sat_nxt  = 1'b1;
    end else if (s12_sum_r < FLUX_MIN) begin
      s13_flux_nxt = FLUX_MIN[31:0];
      s13_sat_nxt  = 1'b1;
    end else begin
      s13_flux_nxt = s12_sum_r[31:0];
      s13_sat_nxt  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0_nu_r  <= s0_nu_nxt;
      s0_neg_r <= s0_neg_nxt;
      s0_fm1_r <= in_data.f_left;
      s0_f0_r  <= in_data.f_center;
      s0_fp1_r <= in_data.f_right;
      s0_e1_r  <= s0_e1_nxt;
      s0_e2_r  <= s0_e2_nxt;
      s0_e3_r  <= s0_e3_nxt;
      s0_e4_r  <= s0_e4_nxt;
      s0_d_r   <= s0_d_nxt;
      s0_g_r   <= s0_g_nxt;
    end
    if (en[1]) begin
      s1_hi1_r  <= s1_hi1_nxt;
      s1_hi2_r  <= s1_hi2_nxt;
      s1_lo1_r  <= s1_lo1_nxt;
      s1_lo2_r  <= s1_lo2_nxt;
      s1_b1_r   <= s1_b1_nxt;
      s1_c1_r   <= s1_c1_nxt;
      s1_b2_r   <= s1_b2_nxt;
      s1_c2_r   <= s1_c2_nxt;
      s1_nu_r   <= s0_nu_r;
      s1_fsel_r <= s0_neg_r ? s0_fp1_r : s0_f0_r;
      s1_f0_r   <= s0_f0_r;
      s1_d_r    <= s0_d_r;
      s1_g_r    <= s0_g_r;
    end
    if (en[2]) begin
      s2_fmax_r <= max34(s1_hi1_r, s1_hi2_r);
      s2_fmin_r <= max34(34'sd0, min34(s1_lo1_r, s1_lo2_r));
      s2_pr1_r  <= s2_mb1[63:0];
      s2_pr2_r  <= s2_mb2[63:0];
      s2_prf_r  <= s2_mf;
      s2_c1_r   <= s1_c1_r;
      s2_c2_r   <= s1_c2_r;
      s2_f0_r   <= s1_f0_r;
      s2_d_r    <= s1_d_r;
      s2_g_r    <= s1_g_r;
    end
    if (en[3]) begin
      s3_p1_r   <= s3_rp1[33:0];
      s3_p2_r   <= s3_rp2[33:0];
      s3_tnu_r  <= s3_rtnu[32:0];
      s3_c1_r   <= s2_c1_r;
      s3_c2_r   <= s2_c2_r;
      s3_lplo_r <= s3_lplo_nxt;
      s3_lphi_r <= s3_lphi_nxt;
      s3_lmhi_r <= s3_lmhi_nxt;
      s3_lmlo_r <= s3_lmlo_nxt;
      s3_d_r    <= s2_d_r;
      s3_g_r    <= s2_g_r;
    end
    if (en[4]) begin
      s4_qr1_r <= s4_mq1[63:0];
      s4_qr2_r <= s4_mq2[63:0];
      s4_lp_r  <= s4_lp_nxt;
      s4_lm_r  <= s4_lm_nxt;
      s4_tnu_r <= s3_tnu_r;
    end
    if (en[5]) begin
      s5_q1_r  <= s5_rq1[33:0];
      s5_q2_r  <= s5_rq2[33:0];
      s5_lp_r  <= s4_lp_r;
      s5_lm_r  <= s4_lm_r;
      s5_tnu_r <= s4_tnu_r;
    end
    if (en[6]) begin
      s6_x1_r  <= s6_aq1p[33:1];
      s6_x2_r  <= s6_aq2p[33:1];
      s6_sg1_r <= s5_q1_r[33];
      s6_sg2_r <= s5_q2_r[33];
      s6_lp_r  <= s5_lp_r;
      s6_lm_r  <= s5_lm_r;
      s6_tnu_r <= s5_tnu_r;
    end
    if (en[7]) begin
      s7_m1_r  <= 66'(s6_x1_r) * 66'(RECIP3);
      s7_m2_r  <= 66'(s6_x2_r) * 66'(RECIP3);
      s7_sg1_r <= s6_sg1_r;
      s7_sg2_r <= s6_sg2_r;
      s7_lp_r  <= s6_lp_r;
      s7_lm_r  <= s6_lm_r;
      s7_tnu_r <= s6_tnu_r;
    end
    if (en[8]) begin
      s8_k1_r  <= s8_k1_nxt;
      s8_k2_r  <= s8_k2_nxt;
      s8_lp_r  <= s7_lp_r;
      s8_lm_r  <= s7_lm_r;
      s8_tnu_r <= s7_tnu_r;
    end
    if (en[9]) begin
      s9_pph1_r <= s9_pph1;
      s9_pph2_r <= s9_pph2;
      s9_ppl1_r <= s9_ppl1;
      s9_ppl2_r <= s9_ppl2;
      s9_tnu_r  <= s8_tnu_r;
    end
    if (en[10]) begin
      s10_kl1_r <= s10_kl1_nxt;
      s10_kl2_r <= s10_kl2_nxt;
      s10_tnu_r <= s9_tnu_r;
    end
    if (en[11]) begin
      s11_t1_r  <= s11_rt1[38:0];
      s11_t2_r  <= s11_rt2[38:0];
      s11_tnu_r <= s10_tnu_r;
    end
    if (en[12]) begin
      s12_sum_r <= s12_sum_nxt;
    end
    if (en[13]) begin
      s13_flux_r <= s13_flux_nxt;
      s13_sat_r  <= s13_sat_nxt;
    end
  end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for pfc_limited_flux. A short table of hand-picked
// stencils comes first, then random stencils sent in bursts. Rows with a
// result are scored against it, the rest against a bit-exact software copy
// of the limiter here. The result side stalls on its own random pattern.
// ----------------------------------------------------------------------------
module tb_top;
  import pfc_pkg::*;

  localparam int     N_RANDOM   = 1930;
  localparam int     HOLD_AT    = 500;
  localparam int     DRAIN_AT   = 1200;
  localparam int     LONG_HOLD  = 150;
  localparam int     IDLE_LIMIT = 1000;
  localparam int     TAIL       = 30;
  localparam longint Q30        = 64'sd1073741824;

  localparam logic signed [31:0] F_ONE   = 32'sh0100_0000;
  localparam logic signed [31:0] F_MAX   = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] F_MIN   = 32'sh8000_0000;
  localparam logic signed [31:0] NU_HALF = 32'sh2000_0000;

  typedef struct packed {
    pfc_in_t  stim;
    logic     known;
    pfc_out_t want;
  } stim_row_t;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_stall;
  pfc_in_t  in_data;
  logic     out_valid;
  logic     out_stall;
  pfc_out_t out_data;

  pfc_out_t  flux_due[$];
  stim_row_t dir_rows[$];
  logic      row_known;
  pfc_out_t  row_want;
  bit        hold_req;
  int        errors;
  int        idle_cycles;
  int        n_in, n_out, n_sat, n_upwind, n_held;

  pfc_limited_flux i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // v / 2^30, nearest, ties away from zero
  function automatic longint round_q30(input longint v);
    longint unsigned m;
    m = (v < 0) ? longint'(-v) : v;
    m = (m + 64'd536870912) >> 30;
    return (v < 0) ? -longint'(m) : longint'(m);
  endfunction

  // nu * b * c / 6, all in Q.30
  function automatic longint poly_coef(input longint nu, input longint b, input longint c);
    longint          q;
    longint unsigned m;
    q = round_q30(round_q30(nu * b) * c);
    m = (q < 0) ? longint'(-q) : q;
    m = (m + 3) / 6;
    return (q < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint larger(input longint a, input longint b);
    return (a > b) ? a : b;
  endfunction

  function automatic longint smaller(input longint a, input longint b);
    return (a < b) ? a : b;
  endfunction

  function automatic pfc_out_t flux_of(input pfc_in_t s);
    longint   fm2, fm1, f0, fp1, fp2, nu;
    longint   hi1, hi2, lo1, lo2, fmax, fmin, lp, lm, k1, k2, sum;
    pfc_out_t r;
    fm2 = s.f_far_left;
    fm1 = s.f_left;
    f0  = s.f_center;
    fp1 = s.f_right;
    fp2 = s.f_far_right;
    nu  = s.courant;
    if (nu > Q30) nu = Q30;
    if (nu < -Q30) nu = -Q30;
    hi1  = larger(larger(fm1, f0), smaller(2 * fm1 - fm2, 2 * f0 - fp1));
    hi2  = larger(larger(fp1, f0), smaller(2 * fp1 - fp2, 2 * f0 - fm1));
    lo1  = smaller(smaller(fm1, f0), larger(2 * fm1 - fm2, 2 * f0 - fp1));
    lo2  = smaller(smaller(fp1, f0), larger(2 * fp1 - fp2, 2 * f0 - fm1));
    fmax = larger(hi1, hi2);
    fmin = larger(0, smaller(lo1, lo2));
    if (nu < 0) begin
      lp  = (f0 >= fp1) ? smaller(2 * (f0 - fmin), f0 - fp1) : larger(2 * (f0 - fmax), f0 - fp1);
      lm  = (fp1 >= fp2) ? smaller(2 * (fmax - f0), fp1 - fp2)
                         : larger(2 * (fmin - f0), fp1 - fp2);
      k1  = poly_coef(nu, Q30 + nu, 2 * Q30 + nu);
      sum = round_q30(nu * fp1);
    end else begin
      lp  = (fp1 >= f0) ? smaller(2 * (f0 - fmin), fp1 - f0) : larger(2 * (f0 - fmax), fp1 - f0);
      lm  = (f0 >= fm1) ? smaller(2 * (fmax - f0), f0 - fm1) : larger(2 * (fmin - f0), f0 - fm1);
      k1  = poly_coef(nu, Q30 - nu, 2 * Q30 - nu);
      sum = round_q30(nu * f0);
    end
    k2  = poly_coef(nu, Q30 - nu, Q30 + nu);
    sum = sum + round_q30(k1 * lp) + round_q30(k2 * lm);
    r.saturated = 1'b0;
    if (sum > 64'sd2147483647) begin
      sum         = 64'sd2147483647;
      r.saturated = 1'b1;
    end else if (sum < -64'sd2147483648) begin
      sum         = -64'sd2147483648;
      r.saturated = 1'b1;
    end
    r.flux = sum[31:0];
    return r;
  endfunction

  function automatic stim_row_t stencil_row(
    input logic signed [31:0] fm2, input logic signed [31:0] fm1,
    input logic signed [31:0] f0, input logic signed [31:0] fp1,
    input logic signed [31:0] fp2, input logic signed [31:0] nu,
    input logic known = 1'b0, input logic signed [31:0] wflux = '0,
    input logic wsat = 1'b0);
    stim_row_t r;
    r.stim = '{f_far_left: fm2, f_left: fm1, f_center: f0, f_right: fp1,
               f_far_right: fp2, courant: nu};
    r.known = known;
    r.want  = '{flux: wflux, saturated: wsat};
    return r;
  endfunction

  function automatic pfc_in_t random_stencil();
    longint  v[5];
    longint  span;
    int      mode;
    pfc_in_t s;
    mode = $urandom_range(0, 9);
    span = longint'(1) << $urandom_range(8, 26);
    v[0] = $urandom_range(0, 32'h0800_0000);
    for (int i = 0; i < 5; i++) begin
      if (mode <= 1) begin
        v[i] = int'($urandom);
      end else if (mode <= 6) begin
        // smooth profile, mostly positive
        if (i > 0) v[i] = v[i-1] + longint'($urandom_range(0, 2 * span)) - span;
      end else if (mode == 7) begin
        case ($urandom_range(0, 5))
          0: v[i] = 0;
          1: v[i] = F_MAX;
          2: v[i] = F_MIN;
          3: v[i] = F_ONE;
          4: v[i] = -F_ONE;
          default: v[i] = int'($urandom);
        endcase
      end else begin
        v[i] = longint'($urandom_range(0, 32'h8000_0000)) - Q30;
      end
    end
    s.f_far_left  = v[0][31:0];
    s.f_left      = v[1][31:0];
    s.f_center    = v[2][31:0];
    s.f_right     = v[3][31:0];
    s.f_far_right = v[4][31:0];
    v[0] = longint'($urandom_range(0, 32'h8000_0000)) - Q30;
    s.courant = v[0][31:0];
    if (mode <= 1 || $urandom_range(0, 7) == 0) s.courant = $urandom;
    else if ($urandom_range(0, 15) == 0) begin
      case ($urandom_range(0, 2))
        0: s.courant = '0;
        1: s.courant = NU_POS_ONE;
        default: s.courant = NU_NEG_ONE;
      endcase
    end
    return s;
  endfunction

  task automatic flag_error(input string what, input pfc_out_t want, input pfc_out_t got);
    errors++;
    if (errors <= 10) begin
      $display("%0t mismatch (%s): expected flux %h sat %b, got flux %h sat %b",
               $realtime, what, want.flux, want.saturated, got.flux, got.saturated);
    end
  endtask

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic xfer(input pfc_in_t d);
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(negedge clk);
    while (flux_due.size() != 0) @(negedge clk);
  endtask

  // scoreboard and watchdog
  always @(posedge clk) begin : score
    pfc_out_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        flux_due.push_back(row_known ? row_want : flux_of(in_data));
        n_in++;
        if (in_data.courant[31]) n_upwind++;
      end
      if (in_stall) n_held++;
      if (out_valid && !out_stall) begin
        n_out++;
        if (out_data.saturated) n_sat++;
        if (flux_due.size() == 0) begin
          flag_error("no transfer pending", '0, out_data);
        end else begin
          want = flux_due.pop_front();
          if (out_data.flux !== want.flux || out_data.saturated !== want.saturated) begin
            flag_error("flux", want, out_data);
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transfer for %0d cycles, %0d fluxes pending",
                 IDLE_LIMIT, flux_due.size());
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  // result side stall pattern
  initial begin : receiver
    int mode;
    int left;
    left = 0;
    mode = 0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        if (left == 0) begin
          mode = $urandom_range(0, 3);
          left = $urandom_range(8, 80);
        end
        left--;
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= left[2];
        endcase
      end
    end
  end

  initial begin : stimulus
    int burst;
    int gap;
    int n;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    out_stall   = 1'b0;
    row_known   = 1'b0;
    row_want    = '0;
    hold_req    = 1'b0;
    errors      = 0;
    idle_cycles = 0;
    n_in = 0; n_out = 0; n_sat = 0; n_upwind = 0; n_held = 0;

    // zero courant gives zero flux whatever the stencil
    dir_rows.push_back(stencil_row(0, 0, 0, 0, 0, 0, 1'b1, 0, 1'b0));
    dir_rows.push_back(stencil_row(F_ONE, 2 * F_ONE, 3 * F_ONE, 4 * F_ONE, 5 * F_ONE, 0,
                                   1'b1, 0, 1'b0));
    dir_rows.push_back(stencil_row(F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, 0, 1'b1, 0, 1'b0));
    // courant of one passes the center value, minus one the negated right value
    dir_rows.push_back(stencil_row(F_MIN, F_MIN, F_MAX, F_MIN, F_MIN, NU_POS_ONE,
                                   1'b1, F_MAX, 1'b0));
    dir_rows.push_back(stencil_row(F_MAX, F_MAX, F_MIN, F_MAX, F_MAX, NU_POS_ONE,
                                   1'b1, F_MIN, 1'b0));
    dir_rows.push_back(stencil_row(0, F_ONE, 2 * F_ONE, F_MIN, F_MAX, NU_NEG_ONE,
                                   1'b1, F_MAX, 1'b1));
    dir_rows.push_back(stencil_row(F_MIN, 0, F_ONE, F_MAX, 0, NU_NEG_ONE,
                                   1'b1, -F_MAX, 1'b0));
    // courant beyond one is clamped first
    dir_rows.push_back(stencil_row(F_ONE, 2 * F_ONE, 3 * F_ONE, F_ONE, 0, 32'sh7FFF_FFFF,
                                   1'b1, 3 * F_ONE, 1'b0));
    dir_rows.push_back(stencil_row(0, F_ONE, 2 * F_ONE, 5 * F_ONE, F_ONE, 32'sh8000_0000,
                                   1'b1, -5 * F_ONE, 1'b0));
    dir_rows.push_back(stencil_row(7, 3, -9, 4, 11, 32'sh4000_0001, 1'b1, -9, 1'b0));
    dir_rows.push_back(stencil_row(7, 3, -9, 4, 11, 32'shBFFF_FFFF, 1'b1, -4, 1'b0));
    // limiter shapes, scored by the predictor
    dir_rows.push_back(stencil_row(F_ONE, 2 * F_ONE, 3 * F_ONE, 4 * F_ONE, 5 * F_ONE,
                                   NU_HALF));
    dir_rows.push_back(stencil_row(5 * F_ONE, 4 * F_ONE, 3 * F_ONE, 2 * F_ONE, F_ONE,
                                   -NU_HALF));
    dir_rows.push_back(stencil_row(F_ONE, 3 * F_ONE, 8 * F_ONE, 2 * F_ONE, F_ONE,
                                   32'sh1333_3333));
    dir_rows.push_back(stencil_row(-F_ONE, -2 * F_ONE, -3 * F_ONE, F_ONE, 4 * F_ONE,
                                   32'shD333_3333));
    dir_rows.push_back(stencil_row(F_MAX, F_MIN, F_MAX, F_MIN, F_MAX, 32'sh1000_0000));
    dir_rows.push_back(stencil_row(F_MIN, F_MAX, F_MIN, F_MAX, F_MIN, 32'shF000_0000));
    dir_rows.push_back(stencil_row(F_MIN, F_MIN, F_MIN, F_MIN, F_MIN, 32'sh0000_0001));
    dir_rows.push_back(stencil_row(F_MAX, F_MAX, F_MAX, F_MAX, F_MAX, 32'shC000_0001));
    dir_rows.push_back(stencil_row(3, -5, 100, -7, 2, 32'sh0000_0001));
    dir_rows.push_back(stencil_row(1000, 2000, 1500, 1200, 900, 32'shFFFF_FFFF));
    dir_rows.push_back(stencil_row(2 * F_ONE, 2 * F_ONE, 2 * F_ONE, 2 * F_ONE, 3 * F_ONE,
                                   NU_HALF));
    dir_rows.push_back(stencil_row(2 * F_ONE, F_ONE, F_ONE, F_ONE, F_ONE, -NU_HALF));
    dir_rows.push_back(stencil_row(F_MAX, 0, F_MAX, 0, F_MAX, 32'sh3FFF_FFFF));

    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (dir_rows[i]) begin
      row_known = dir_rows[i].known;
      row_want  = dir_rows[i].want;
      xfer(dir_rows[i].stim);
    end
    drain();

    row_known = 1'b0;
    n = 0;
    while (n < N_RANDOM) begin
      burst = $urandom_range(1, 48);
      gap   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      // keep offering while the result side holds off
      if (gap > 0 && !hold_req) begin
        in_valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
      for (int k = 0; k < burst && n < N_RANDOM; k++) begin
        if (n == HOLD_AT) hold_req = 1'b1;
        if (n == DRAIN_AT) drain();
        xfer(random_stencil());
        n++;
      end
    end
    drain();
    repeat (TAIL) @(negedge clk);

    $display("%0d stencils sent, %0d fluxes scored, %0d saturated, %0d with negative courant",
             n_in, n_out, n_sat, n_upwind);
    $display("input held back for %0d cycles, %0d mismatches", n_held, errors);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[sim.f]
hw/rtl/pfc_pkg.sv
hw/rtl/pfc_limited_flux.sv
test/tb_top.sv
